FILE: sv/rmsvad_pkg.sv
// Package for the RMS voice activity detector.
// Holds the register map, the configuration record and the decision FSM codes.
// No dependencies.
package rmsvad_pkg;

   // APB register map: register i at byte address 4*i
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_THRESHOLD  = 2'd0;
   localparam logic [1:0] REG_RELEASE    = 2'd1;
   localparam logic [1:0] REG_MIN_ACTIVE = 2'd2;

   localparam logic [14:0] THRESHOLD_RESET  = 15'd1638;
   localparam logic [15:0] RELEASE_RESET    = 16'd200;
   localparam logic [15:0] MIN_ACTIVE_RESET = 16'd100;

   // square of a 17-bit magnitude of at most 2^15 fits in 31 bits
   localparam int MAG_W    = 17;
   localparam int SQUARE_W = 31;
   localparam int THR_SQ_W = 30;

   typedef struct packed {
      logic [15:0] min_active_time_ms;
      logic [15:0] release_time_ms;
      logic [14:0] threshold_q15;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SQUARE = 4'b0010,
      ST_SCALE  = 4'b0100,
      ST_DECIDE = 4'b1000
   } back_state_type;

endpackage

FILE: sv/rmsvad_front.sv
// Front end of the RMS voice activity detector: takes samples, squares and
// accumulates them, and hands one summary per frame to the queue.
// Depends on rmsvad_pkg.
module rmsvad_front #(
   parameter int FRAME_MAX = 4096,
   parameter int TALLY_W   = $clog2(FRAME_MAX + 1),
   parameter int ENERGY_W  = rmsvad_pkg::SQUARE_W + TALLY_W
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [15:0]         pcm_sample,
   input  logic                frame_end,
   input  logic [15:0]         given_rms_q15,
   input  logic [31:0]         time_now_ms,
   output logic                push,
   input  logic                push_ready,
   output logic [ENERGY_W-1:0] push_energy,
   output logic [TALLY_W-1:0]  push_tally,
   output logic [15:0]         push_given,
   output logic [31:0]         push_now
);

   localparam int MAG_W = rmsvad_pkg::MAG_W;
   localparam logic [TALLY_W-1:0] TALLY_LIMIT = TALLY_W'(FRAME_MAX);

   logic                     accept;
   logic                     take;
   logic                     advance;
   logic                     s2_fire;
   logic [TALLY_W-1:0]       tally_ff, tally_in, tally_now;
   logic [ENERGY_W-1:0]      energy_ff, energy_in, energy_sum;
   logic [rmsvad_pkg::MAG_W-1:0] mag;

   // stage 1: sample magnitude
   logic                     s1_valid_ff, s1_valid_in;
   logic [rmsvad_pkg::MAG_W-1:0] s1_mag_ff;
   logic                     s1_take_ff, s1_last_ff;
   logic [15:0]              s1_given_ff;
   logic [31:0]              s1_now_ff;
   logic [TALLY_W-1:0]       s1_tally_ff;

   // stage 2: square
   logic                     s2_valid_ff, s2_valid_in;
   logic [rmsvad_pkg::SQUARE_W-1:0] s2_sq_ff;
   logic [2*rmsvad_pkg::MAG_W-1:0]  sq_full;
   logic                     s2_take_ff, s2_last_ff;
   logic [15:0]              s2_given_ff;
   logic [31:0]              s2_now_ff;
   logic [TALLY_W-1:0]       s2_tally_ff;

   assign s2_fire   = s2_valid_ff & (~s2_last_ff | push_ready);
   assign advance   = ~s2_valid_ff | s2_fire;
   assign req_ready = advance | ~s1_valid_ff;
   assign accept    = req_valid & req_ready;

   // samples past the frame limit are dropped
   assign take      = (tally_ff < TALLY_LIMIT);
   assign tally_now = tally_ff + TALLY_W'(take);
   assign mag       = pcm_sample[15] ? (MAG_W'(17'h10000) - {1'b0, pcm_sample})
                                     : {1'b0, pcm_sample};

   always_comb begin
      tally_in = tally_ff;
      if (accept) begin
         tally_in = frame_end ? '0 : tally_now;
      end
   end

   assign s1_valid_in = accept | (s1_valid_ff & ~advance);
   assign s2_valid_in = (s1_valid_ff & advance) | (s2_valid_ff & ~s2_fire);
   assign sq_full     = s1_mag_ff * s1_mag_ff;

   assign energy_sum = energy_ff + (s2_take_ff ? ENERGY_W'(s2_sq_ff) : '0);

   always_comb begin
      energy_in = energy_ff;
      if (s2_fire) begin
         energy_in = s2_last_ff ? '0 : energy_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff    <= '0;
         energy_ff   <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         tally_ff    <= tally_in;
         energy_ff   <= energy_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mag_ff   <= mag;
         s1_take_ff  <= take;
         s1_last_ff  <= frame_end;
         s1_given_ff <= given_rms_q15;
         s1_now_ff   <= time_now_ms;
         s1_tally_ff <= tally_now;
      end
      if (s1_valid_ff & advance) begin
         s2_sq_ff    <= sq_full[rmsvad_pkg::SQUARE_W-1:0];
         s2_take_ff  <= s1_take_ff;
         s2_last_ff  <= s1_last_ff;
         s2_given_ff <= s1_given_ff;
         s2_now_ff   <= s1_now_ff;
         s2_tally_ff <= s1_tally_ff;
      end
   end

   assign push        = s2_fire & s2_last_ff;
   assign push_energy = energy_sum;
   assign push_tally  = s2_tally_ff;
   assign push_given  = s2_given_ff;
   assign push_now    = s2_now_ff;

endmodule

FILE: sv/rmsvad_queue.sv
// Two-entry queue of frame summaries between front and back end.
// No dependencies.
module rmsvad_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_pop,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_write, do_read;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_data  = entry_ff[rd_ptr_ff];
   assign do_write = wr_valid & wr_ready;
   assign do_read  = rd_pop & rd_valid;

   assign wr_ptr_in = wr_ptr_ff ^ do_write;
   assign rd_ptr_in = rd_ptr_ff ^ do_read;
   assign count_in  = count_ff + 2'(do_write) - 2'(do_read);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: sv/rmsvad_back.sv
// Back end of the RMS voice activity detector: judges each frame loud or
// quiet, runs the hangover timers and registers the result.
// Depends on rmsvad_pkg.
module rmsvad_back #(
   parameter int TALLY_W  = 13,
   parameter int ENERGY_W = rmsvad_pkg::SQUARE_W + TALLY_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rmsvad_pkg::cfg_type  cfg,
   input  logic                 q_valid,
   output logic                 q_pop,
   input  logic [ENERGY_W-1:0]  q_energy,
   input  logic [TALLY_W-1:0]   q_tally,
   input  logic [15:0]          q_given,
   input  logic [31:0]          q_now,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_active,
   output logic                 active_state
);

   localparam int THR_W  = rmsvad_pkg::THR_SQ_W;
   localparam int PROD_W = THR_W + TALLY_W;

   rmsvad_pkg::back_state_type state_ff, state_in;

   logic [ENERGY_W-1:0] energy_ff;
   logic [TALLY_W-1:0]  tally_ff;
   logic [15:0]         given_ff;
   logic [31:0]         now_ff;
   logic [THR_W-1:0]    thr_sq_ff;
   logic [ENERGY_W-1:0] limit_ff;
   logic [PROD_W-1:0]   product;
   logic [THR_W-1:0]    thr_sq;

   logic        active_ff, active_in;
   logic [31:0] last_loud_ff, last_loud_in;
   logic [31:0] last_change_ff, last_change_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_active_ff, rsp_active_in;

   logic        out_free, loud, released;
   logic [31:0] since_loud, since_change;

   assign thr_sq  = {15'd0, cfg.threshold_q15} * {15'd0, cfg.threshold_q15};
   assign product = {{TALLY_W{1'b0}}, thr_sq_ff} * {{THR_W{1'b0}}, tally_ff};

   assign out_free = ~rsp_valid_ff | rsp_ready;
   assign loud     = (given_ff != 16'd0) ? (given_ff >= {1'b0, cfg.threshold_q15})
                                         : (energy_ff >= limit_ff);

   // elapsed times wrap modulo 2^32
   assign since_loud   = now_ff - last_loud_ff;
   assign since_change = now_ff - last_change_ff;
   assign released     = (since_loud > {16'd0, cfg.release_time_ms}) &&
                         (since_change > {16'd0, cfg.min_active_time_ms});

   assign q_pop = (state_ff == rmsvad_pkg::ST_IDLE) & q_valid;

   always_comb begin
      state_in       = state_ff;
      active_in      = active_ff;
      last_loud_in   = last_loud_ff;
      last_change_in = last_change_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_ready;
      rsp_active_in  = rsp_active_ff;
      unique case (state_ff)
         rmsvad_pkg::ST_IDLE: begin
            if (q_valid) begin
               state_in = rmsvad_pkg::ST_SQUARE;
            end
         end
         rmsvad_pkg::ST_SQUARE: begin
            state_in = rmsvad_pkg::ST_SCALE;
         end
         rmsvad_pkg::ST_SCALE: begin
            state_in = rmsvad_pkg::ST_DECIDE;
         end
         rmsvad_pkg::ST_DECIDE: begin
            // hold until the result register can take a new value
            if (out_free) begin
               state_in = rmsvad_pkg::ST_IDLE;
               if (loud) begin
                  last_loud_in = now_ff;
                  if (!active_ff) begin
                     active_in      = 1'b1;
                     last_change_in = now_ff;
                     rsp_valid_in   = 1'b1;
                     rsp_active_in  = 1'b1;
                  end
               end else if (active_ff && released) begin
                  active_in      = 1'b0;
                  last_change_in = now_ff;
                  rsp_valid_in   = 1'b1;
                  rsp_active_in  = 1'b0;
               end
            end
         end
         default: begin
            state_in = rmsvad_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rmsvad_pkg::ST_IDLE;
         active_ff      <= 1'b0;
         last_loud_ff   <= '0;
         last_change_ff <= '0;
         rsp_valid_ff   <= 1'b0;
         rsp_active_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         active_ff      <= active_in;
         last_loud_ff   <= last_loud_in;
         last_change_ff <= last_change_in;
         rsp_valid_ff   <= rsp_valid_in;
         rsp_active_ff  <= rsp_active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         energy_ff <= q_energy;
         tally_ff  <= q_tally;
         given_ff  <= q_given;
         now_ff    <= q_now;
      end
      if (state_ff == rmsvad_pkg::ST_SQUARE) begin
         thr_sq_ff <= thr_sq;
      end
      if (state_ff == rmsvad_pkg::ST_SCALE) begin
         limit_ff <= ENERGY_W'(product);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_active   = rsp_active_ff;
   assign active_state = active_ff;

endmodule

FILE: sv/rms_voice_activity_detector_unit.sv
// Top level of the RMS voice activity detector.
// Depends on rmsvad_pkg, rmsvad_front, rmsvad_queue and rmsvad_back.
//
// Usage:
//   req_*  stream of 16-bit PCM samples, one per request; req_tlast marks the
//          last sample of a frame, which carries the frame's given RMS and
//          its millisecond timestamp.
//   rsp_*  one request whenever the voice state changes; rsp_tdata[0] is the
//          new state.
//   csr_*  APB port: threshold_q15 at 0x0, release_time_ms at 0x4,
//          min_active_time_ms at 0x8. Write only while the block is idle.
// Throughput: one sample per cycle while the queue has room. Each frame end
// passes through the decision sequencer (threshold square, scale by count,
// compare and update); a two-entry queue lets the sample path run on while it
// works, so short frames back to back can fill the queue and stall the input.
// Path of a frame-end sample to rsp_tvalid: magnitude stage, square stage,
// queue, then the sequencer's idle, square, scale and decide states.
// Reset clears the running sums, the queue and the voice state (inactive,
// timestamps zero) and loads the register defaults. A stalled rsp_tready
// holds the result; the sample path keeps running until the queue fills.
module rms_voice_activity_detector_unit #(
   parameter int FRAME_MAX = 4096
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: pcm_sample[15:0], given_rms_q15[31:16], time_now_ms[63:32]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic        req_tlast,
   // rsp_tdata: voice_active[0], zero fill [7:1]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [rmsvad_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [rmsvad_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [rmsvad_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic        csr_pready
);

   localparam int TALLY_W  = $clog2(FRAME_MAX + 1);
   localparam int ENERGY_W = rmsvad_pkg::SQUARE_W + TALLY_W;
   localparam int ENTRY_W  = ENERGY_W + TALLY_W + 16 + 32;

   rmsvad_pkg::cfg_type cfg_ff, cfg_in;
   logic                csr_wr;
   logic [1:0]          csr_index;

   logic                push, push_ready;
   logic [ENERGY_W-1:0] push_energy, q_energy;
   logic [TALLY_W-1:0]  push_tally, q_tally;
   logic [15:0]         push_given, q_given;
   logic [31:0]         push_now, q_now;
   logic                q_valid, q_pop;
   logic                rsp_active;
   logic                active_state;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_index)
            rmsvad_pkg::REG_THRESHOLD:  cfg_in.threshold_q15      = csr_pwdata[14:0];
            rmsvad_pkg::REG_RELEASE:    cfg_in.release_time_ms    = csr_pwdata[15:0];
            rmsvad_pkg::REG_MIN_ACTIVE: cfg_in.min_active_time_ms = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         rmsvad_pkg::REG_THRESHOLD:  csr_prdata = {17'd0, cfg_ff.threshold_q15};
         rmsvad_pkg::REG_RELEASE:    csr_prdata = {16'd0, cfg_ff.release_time_ms};
         rmsvad_pkg::REG_MIN_ACTIVE: csr_prdata = {16'd0, cfg_ff.min_active_time_ms};
         default:                    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_q15      <= rmsvad_pkg::THRESHOLD_RESET;
         cfg_ff.release_time_ms    <= rmsvad_pkg::RELEASE_RESET;
         cfg_ff.min_active_time_ms <= rmsvad_pkg::MIN_ACTIVE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rmsvad_front #(
      .FRAME_MAX (FRAME_MAX),
      .TALLY_W   (TALLY_W),
      .ENERGY_W  (ENERGY_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .pcm_sample    (req_tdata[15:0]),
      .frame_end     (req_tlast),
      .given_rms_q15 (req_tdata[31:16]),
      .time_now_ms   (req_tdata[63:32]),
      .push          (push),
      .push_ready    (push_ready),
      .push_energy   (push_energy),
      .push_tally    (push_tally),
      .push_given    (push_given),
      .push_now      (push_now)
   );

   rmsvad_queue #(
      .WIDTH (ENTRY_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push),
      .wr_ready (push_ready),
      .wr_data  ({push_energy, push_tally, push_given, push_now}),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_data  ({q_energy, q_tally, q_given, q_now})
   );

   rmsvad_back #(
      .TALLY_W  (TALLY_W),
      .ENERGY_W (ENERGY_W)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_energy     (q_energy),
      .q_tally      (q_tally),
      .q_given      (q_given),
      .q_now        (q_now),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_active   (rsp_active),
      .active_state (active_state)
   );

   assign rsp_tdata = {7'd0, rsp_active};

   // a pending result always shows the current voice state
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] == active_state))
      else $error("pending result disagrees with voice state");

   // two results back to back must alternate
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) ##1 rsp_tvalid |-> rsp_tdata[0] != $past(rsp_tdata[0]))
      else $error("repeated voice state result");

   assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_index == rmsvad_pkg::REG_RELEASE) |=>
      (cfg_ff.release_time_ms == $past(csr_pwdata[15:0])))
      else $error("release time register not written");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

FILE: tb/rms_voice_activity_detector_unit_test.sv
`timescale 1ns / 1ps
// Testbench for rms_voice_activity_detector_unit: drives PCM sample requests and
// APB register writes, predicts each voice state change and checks every result.
// Depends on rmsvad_pkg and the detector RTL.
module rms_voice_activity_detector_unit_test;

   localparam int FRAME_LIMIT = 4096;
   localparam int SETTLE_CYCLES = 48;
   localparam int DRAIN_LIMIT = 20000;
   localparam logic [1:0] REG_SPARE = 2'd3;

   logic clock;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // req_tdata: pcm_sample[15:0], given_rms_q15[31:16], time_now_ms[63:32]
   logic [63:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: voice_active[0], zero fill [7:1]
   logic [7:0]  rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [rmsvad_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [rmsvad_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [rmsvad_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic        csr_pready;

   // predicted detector state
   rmsvad_pkg::cfg_type vad_cfg;
   logic        vad_active;
   logic [31:0] vad_last_loud_ms;
   logic [31:0] vad_last_change_ms;
   logic [63:0] vad_energy;
   int unsigned vad_tally;
   bit          expected_voice_state[$];

   logic [31:0] stamp_ms = '0;
   int          fail_count = 0;
   int          sender_gap_max = 8;
   int          rsp_gap_max = 8;
   int          rsp_hold_cycles = 0;
   bit          head_state;

   rms_voice_activity_detector_unit #(
      .FRAME_MAX(FRAME_LIMIT)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   // Accumulate one sample; on frame end decide and queue the new state if it changes.
   task automatic predict_voice_change(input logic signed [15:0] pcm, input logic frame_end,
                                       input logic [15:0] given, input logic [31:0] now);
      logic [63:0] square;
      logic [63:0] floor_energy;
      logic [31:0] since_loud;
      logic [31:0] since_change;
      logic        loud;
      square = 64'(longint'(pcm) * longint'(pcm));
      if (vad_tally < FRAME_LIMIT) begin
         vad_energy += square;
         vad_tally++;
      end
      if (!frame_end)
         return;
      if (given != 16'd0) begin
         loud = given >= 16'(vad_cfg.threshold_q15);
      end else begin
         floor_energy = 64'(vad_cfg.threshold_q15) * 64'(vad_cfg.threshold_q15) * 64'(vad_tally);
         loud = vad_energy >= floor_energy;
      end
      vad_energy = '0;
      vad_tally = 0;
      if (loud) begin
         vad_last_loud_ms = now;
         if (!vad_active) begin
            vad_active = 1'b1;
            vad_last_change_ms = now;
            expected_voice_state.push_back(1'b1);
         end
      end else if (vad_active) begin
         since_loud = now - vad_last_loud_ms;
         since_change = now - vad_last_change_ms;
         if (since_loud > 32'(vad_cfg.release_time_ms) &&
             since_change > 32'(vad_cfg.min_active_time_ms)) begin
            vad_active = 1'b0;
            vad_last_change_ms = now;
            expected_voice_state.push_back(1'b0);
         end
      end
   endtask

   // Starts and ends at a falling edge.
   task automatic send_sample(input logic signed [15:0] pcm, input logic frame_end,
                              input logic [15:0] given, input logic [31:0] now);
      int gap;
      gap = $urandom_range(0, sender_gap_max);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {now, given, pcm};
      req_tlast <= frame_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_voice_change(pcm, frame_end, given, now);
      @(negedge clock);
   endtask

   // Samples drawn within +/-amp (or any 16-bit value when noisy); only the last
   // request carries the real given RMS and timestamp.
   task automatic send_frame(input int len, input int amp, input bit noisy,
                             input logic [15:0] given, input logic [31:0] now);
      logic signed [15:0] pcm;
      int k;
      for (k = 0; k < len; k++) begin
         if (noisy)
            pcm = 16'($urandom);
         else
            pcm = 16'(int'($urandom_range(0, 2 * amp)) - amp);
         if (k == len - 1)
            send_sample(pcm, 1'b1, given, now);
         else
            send_sample(pcm, 1'b0, 16'($urandom), $urandom);
      end
   endtask

   task automatic wait_results_done;
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (expected_voice_state.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      if (expected_voice_state.size() != 0) begin
         $error("voice_active: %0d expected results never arrived",
                expected_voice_state.size());
         fail_count++;
         expected_voice_state.delete();
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (index)
         rmsvad_pkg::REG_THRESHOLD:  vad_cfg.threshold_q15 = value[14:0];
         rmsvad_pkg::REG_RELEASE:    vad_cfg.release_time_ms = value[15:0];
         rmsvad_pkg::REG_MIN_ACTIVE: vad_cfg.min_active_time_ms = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic csr_check(input logic [1:0] index);
      logic [31:0] want;
      case (index)
         rmsvad_pkg::REG_THRESHOLD: want = 32'(vad_cfg.threshold_q15);
         rmsvad_pkg::REG_RELEASE:   want = 32'(vad_cfg.release_time_ms);
         default:                   want = 32'(vad_cfg.min_active_time_ms);
      endcase
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {index, 2'b00};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== want) begin
         $error("csr_prdata[%0d]: expected 0x%08h, got 0x%08h", index, want, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_config(input int thr, input int rel, input int min_act);
      csr_write(rmsvad_pkg::REG_THRESHOLD, 32'(thr));
      csr_write(rmsvad_pkg::REG_RELEASE, 32'(rel));
      csr_write(rmsvad_pkg::REG_MIN_ACTIVE, 32'(min_act));
   endtask

   task automatic test_register_access;
      csr_check(rmsvad_pkg::REG_THRESHOLD);
      csr_check(rmsvad_pkg::REG_RELEASE);
      csr_check(rmsvad_pkg::REG_MIN_ACTIVE);
      // write past the last register must be ignored
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      csr_write(rmsvad_pkg::REG_THRESHOLD, 32'hFFFF_FFFF);
      csr_write(rmsvad_pkg::REG_RELEASE, 32'hFFFF_FFFF);
      csr_write(rmsvad_pkg::REG_MIN_ACTIVE, 32'hFFFF_FFFF);
      csr_check(rmsvad_pkg::REG_THRESHOLD);
      csr_check(rmsvad_pkg::REG_RELEASE);
      csr_check(rmsvad_pkg::REG_MIN_ACTIVE);
      set_config(rmsvad_pkg::THRESHOLD_RESET, rmsvad_pkg::RELEASE_RESET,
                 rmsvad_pkg::MIN_ACTIVE_RESET);
      csr_check(rmsvad_pkg::REG_THRESHOLD);
   endtask

   // Default registers: threshold 1638, release 200 ms, min active 100 ms.
   task automatic test_directed_decisions;
      send_sample(16'sd32767, 1'b1, 16'd0, 32'd1000);
      send_sample(16'h8000, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
      send_sample(16'h8000, 1'b1, 16'd0, 32'd1050);
      // release boundary must be strictly exceeded
      send_sample(16'sd0, 1'b1, 16'd0, 32'd1250);
      send_sample(16'sd0, 1'b1, 16'd0, 32'd1251);
      // rms exactly at threshold is loud, one below is quiet
      send_sample(16'sd1638, 1'b1, 16'd0, 32'd1300);
      send_sample(-16'sd1637, 1'b1, 16'd0, 32'd1301);
      // nonzero given RMS overrides the samples
      send_sample(16'sd32767, 1'b1, 16'd1, 32'd1600);
      send_sample(16'sd0, 1'b1, 16'd1638, 32'd1700);
      send_sample(16'sd0, 1'b1, 16'd1637, 32'd2000);
      send_sample(16'sd0, 1'b1, 16'h8000, 32'd2100);
      send_sample(16'sd0, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
      // timestamp wraps through zero
      send_sample(16'sd0, 1'b1, 16'd0, 32'h0000_0010);
      send_sample(16'sd0, 1'b1, 16'd0, 32'h0000_0100);
      // timestamp going backwards reads as a long gap
      send_sample(16'sd0, 1'b1, 16'h8000, 32'd5000);
      send_sample(16'sd0, 1'b1, 16'd0, 32'd4000);
      stamp_ms = 32'd10000;
      wait_results_done();
   endtask

   // Every frame flips the state while the sink holds off, so the block backs up.
   task automatic test_output_backpressure;
      int k;
      sender_gap_max = 0;
      set_config(rmsvad_pkg::THRESHOLD_RESET, 0, 0);
      rsp_hold_cycles = 300;
      for (k = 0; k < 40; k++) begin
         stamp_ms += 32'd1;
         send_sample(k[0] ? 16'sd0 : 16'sd32767, 1'b1, 16'd0, stamp_ms);
      end
      wait_results_done();
   endtask

   task automatic run_random_frames(input int item_budget);
      int sent;
      int len;
      int amp;
      int thr;
      int step_max;
      logic [15:0] given;
      sent = 0;
      while (sent < item_budget) begin
         thr = vad_cfg.threshold_q15;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         amp = $urandom_range(0, 3 * thr + 16);
         if (amp > 32767)
            amp = 32767;
         case ($urandom_range(0, 11))
            0, 1, 2: given = 16'($urandom_range(thr / 2, 2 * thr + 1));
            3:       given = 16'($urandom);
            default: given = 16'd0;
         endcase
         step_max = int'(vad_cfg.release_time_ms) / 2 + 60;
         if ($urandom_range(0, 15) == 0)
            stamp_ms += $urandom;
         else
            stamp_ms += $urandom_range(0, step_max);
         send_frame(len, amp, $urandom_range(0, 9) == 0, given, stamp_ms);
         sent += len;
      end
   endtask

   task automatic test_random_settings;
      int phase;
      int thr;
      sender_gap_max = 8;
      rsp_gap_max = 8;
      set_config(rmsvad_pkg::THRESHOLD_RESET, rmsvad_pkg::RELEASE_RESET,
                 rmsvad_pkg::MIN_ACTIVE_RESET);
      run_random_frames(100);
      // sender pauses until everything is back, then resumes
      wait_results_done();
      run_random_frames(100);
      wait_results_done();

      sender_gap_max = 0;
      rsp_gap_max = 0;
      set_config(0, 0, 0);
      run_random_frames(80);
      wait_results_done();

      sender_gap_max = 8;
      rsp_gap_max = 8;
      set_config(32767, 65535, 65535);
      run_random_frames(80);
      wait_results_done();

      for (phase = 0; phase < 4; phase++) begin
         sender_gap_max = $urandom_range(0, 1) * 8;
         rsp_gap_max = $urandom_range(0, 1) * 8;
         thr = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 6000);
         set_config(thr, $urandom_range(0, 400), $urandom_range(0, 400));
         run_random_frames(130);
         wait_results_done();
      end
   endtask

   initial begin : response_sink
      int stall;
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, rsp_gap_max);
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready) && rsp_hold_cycles == 0) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_voice_state.size() == 0) begin
            $error("voice_active: expected nothing, got %0d", rsp_tdata[0]);
            fail_count++;
         end else begin
            head_state = expected_voice_state.pop_front();
            if (rsp_tdata[0] !== head_state) begin
               $error("voice_active: expected %0d, got %0d", head_state, rsp_tdata[0]);
               fail_count++;
            end
         end
      end
   end

   initial begin
      vad_cfg.threshold_q15 = rmsvad_pkg::THRESHOLD_RESET;
      vad_cfg.release_time_ms = rmsvad_pkg::RELEASE_RESET;
      vad_cfg.min_active_time_ms = rmsvad_pkg::MIN_ACTIVE_RESET;
      vad_active = 1'b0;
      vad_last_loud_ms = '0;
      vad_last_change_ms = '0;
      vad_energy = '0;
      vad_tally = 0;
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_register_access();
      test_directed_decisions();
      test_output_backpressure();
      test_random_settings();
      wait_results_done();

      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: rms_voice_activity_detector_unit.f
sv/rmsvad_pkg.sv
sv/rmsvad_front.sv
sv/rmsvad_queue.sv
sv/rmsvad_back.sv
sv/rms_voice_activity_detector_unit.sv
tb/rms_voice_activity_detector_unit_test.sv
